// ===== rtl/core/hcd_pkg.sv =====
// Package for the Huffman container decoder.
// Holds shared defaults, the leaf marker code and the node-store write-enable group.
// No dependencies.
package hcd_pkg;

  localparam int TREE_BYTES_DEF       = 1024;
  localparam int SIZE_FIELD_BYTES_DEF = 8;

  localparam logic [7:0] LEAF_MARK = 8'd1;

  localparam logic STATUS_SYMBOL = 1'b0;
  localparam logic STATUS_OVERSIZE = 1'b1;

  typedef struct packed {
    logic sym;
    logic kid0;
    logic kid1;
  } node_we_t;

endpackage

// ===== rtl/core/huffman_container_decoder_unit.sv =====
// Top level of the Huffman container decoder: header parse, tree build, bit walk.
// Uses hcd_pkg, hcd_node_store and hcd_slot_stack.
//
// Takes one container byte per transaction: a little-endian tree length and symbol
// count of SIZE_FIELD_BYTES each, a preorder tree, then code bits MSB first. The
// input stalls while a byte is worked on. A header byte is accepted, dispatched and
// finished; a tree byte adds node write, stack pop and link, and two slot pushes
// as needed; a data byte steps each code bit through the node-table reads that its
// step depends on (root fetch, child fetch, emit), and emitted symbols wait while
// the output is stalled. The final result of each byte carries run_last. A tree
// length above TREE_BYTES gives one result with status 1, and bytes are dropped
// until stream_end.
module huffman_container_decoder_unit
  import hcd_pkg::*;
#(
  parameter int TREE_BYTES       = TREE_BYTES_DEF,
  parameter int SIZE_FIELD_BYTES = SIZE_FIELD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       stream_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] symbol,
  output logic       status,
  output logic       run_last,
  output logic       all_done
);

  localparam int NAW = $clog2(TREE_BYTES);
  localparam int NW  = $clog2(TREE_BYTES + 1);
  localparam int SAW = $clog2(TREE_BYTES + 1);
  localparam int SW  = $clog2(TREE_BYTES + 2);
  localparam int FW  = 8 * SIZE_FIELD_BYTES;
  localparam logic [NW-1:0] NODE_NULL = NW'(TREE_BYTES);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TREE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_DRAIN  = 2'd3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_TB    = 4'd2;
  localparam logic [3:0] S_MK    = 4'd3;
  localparam logic [3:0] S_LINK  = 4'd4;
  localparam logic [3:0] S_PUSH1 = 4'd5;
  localparam logic [3:0] S_PUSH2 = 4'd6;
  localparam logic [3:0] S_BIT   = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]    state;
  logic [1:0]    phase;
  logic [3:0]    header_count;
  logic [FW-1:0] tree_bytes_left;
  logic [FW-1:0] symbols_left;
  logic [SW-1:0] stack_count;
  logic [NW-1:0] build_cursor;
  logic          awaiting_symbol;
  logic          root_valid;
  logic          walk_null;
  logic [NW-1:0] cur_kid0;
  logic [NW-1:0] cur_kid1;
  logic [7:0]    cur_byte;
  logic          end_flag;
  logic [2:0]    bit_idx;
  logic [NW-1:0] new_node;
  logic          mk_internal;
  logic [7:0]    mk_sym;
  logic          hold_valid;
  logic [7:0]    hold_sym;
  logic          hold_status;
  logic          hold_done;
  logic [7:0]    new_sym;
  logic          new_done;

  logic [FW-1:0] tbl_hdr;
  logic [FW-1:0] sl_hdr;
  logic          out_free;
  logic          dir;
  logic [NW-1:0] child;
  logic          child_leaf;

  node_we_t       nd_we;
  logic [NAW-1:0] nd_wr_addr;
  logic [7:0]     nd_wr_sym;
  logic [NW-1:0]  nd_wr_kid0;
  logic [NW-1:0]  nd_wr_kid1;
  logic [NAW-1:0] nd_rd_addr;
  logic [7:0]     nd_rd_sym;
  logic [NW-1:0]  nd_rd_kid0;
  logic [NW-1:0]  nd_rd_kid1;

  logic           st_we;
  logic [SAW-1:0] st_wr_addr;
  logic           st_wr_side;
  logic [SAW-1:0] st_rd_addr;
  logic [NW-1:0]  st_rd_node;
  logic           st_rd_side;

  hcd_node_store #(.TREE_BYTES(TREE_BYTES), .NAW(NAW), .NW(NW)) u_nodes (
    .clk     (clk),
    .we      (nd_we),
    .wr_addr (nd_wr_addr),
    .wr_sym  (nd_wr_sym),
    .wr_kid0 (nd_wr_kid0),
    .wr_kid1 (nd_wr_kid1),
    .rd_addr (nd_rd_addr),
    .rd_sym  (nd_rd_sym),
    .rd_kid0 (nd_rd_kid0),
    .rd_kid1 (nd_rd_kid1)
  );

  hcd_slot_stack #(.TREE_BYTES(TREE_BYTES), .SAW(SAW), .NW(NW)) u_stack (
    .clk     (clk),
    .we      (st_we),
    .wr_addr (st_wr_addr),
    .wr_node (new_node),
    .wr_side (st_wr_side),
    .rd_addr (st_rd_addr),
    .rd_node (st_rd_node),
    .rd_side (st_rd_side)
  );

  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign dir        = cur_byte[bit_idx];
  assign child      = dir ? cur_kid1 : cur_kid0;
  assign child_leaf = (nd_rd_kid0 == NODE_NULL) && (nd_rd_kid1 == NODE_NULL);

  always_comb begin
    tbl_hdr = tree_bytes_left;
    sl_hdr  = symbols_left;
    for (int i = 0; i < SIZE_FIELD_BYTES; i++) begin
      if (header_count == 4'(i)) begin
        tbl_hdr[8*i +: 8] = tree_bytes_left[8*i +: 8] | cur_byte;
      end
      if (header_count == 4'(SIZE_FIELD_BYTES + i)) begin
        sl_hdr[8*i +: 8] = symbols_left[8*i +: 8] | cur_byte;
      end
    end
  end

  always_comb begin
    nd_we      = '0;
    nd_wr_addr = build_cursor[NAW-1:0];
    nd_wr_sym  = mk_sym;
    nd_wr_kid0 = NODE_NULL;
    nd_wr_kid1 = NODE_NULL;
    nd_rd_addr = walk_null ? '0 : child[NAW-1:0];
    st_we      = 1'b0;
    st_wr_addr = stack_count[SAW-1:0];
    st_wr_side = 1'b1;
    st_rd_addr = SAW'(stack_count - SW'(1));
    unique case (state)
      S_MK: begin
        if (build_cursor < NW'(TREE_BYTES)) begin
          nd_we = '{sym: 1'b1, kid0: 1'b1, kid1: 1'b1};
        end
      end
      S_LINK: begin
        nd_wr_addr = st_rd_node[NAW-1:0];
        nd_wr_kid0 = new_node;
        nd_wr_kid1 = new_node;
        nd_we      = '{sym: 1'b0, kid0: !st_rd_side, kid1: st_rd_side};
      end
      S_PUSH1: begin
        st_we = (stack_count < SW'(TREE_BYTES + 1));
      end
      S_PUSH2: begin
        st_we      = (stack_count < SW'(TREE_BYTES + 1));
        st_wr_side = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_HEADER;
      header_count    <= '0;
      tree_bytes_left <= '0;
      symbols_left    <= '0;
      stack_count     <= '0;
      build_cursor    <= '0;
      awaiting_symbol <= 1'b0;
      root_valid      <= 1'b0;
      walk_null       <= 1'b1;
      hold_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_byte <= in_byte;
            end_flag <= stream_end;
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          state <= S_FIN;
          case (phase)
            PH_HEADER: begin
              tree_bytes_left <= tbl_hdr;
              symbols_left    <= sl_hdr;
              header_count    <= header_count + 4'd1;
              if (header_count == 4'(2 * SIZE_FIELD_BYTES - 1)) begin
                header_count <= '0;
                if (tbl_hdr > FW'(TREE_BYTES)) begin
                  hold_valid  <= 1'b1;
                  hold_sym    <= '0;
                  hold_status <= STATUS_OVERSIZE;
                  hold_done   <= 1'b0;
                  phase       <= PH_DRAIN;
                end else begin
                  stack_count     <= '0;
                  build_cursor    <= '0;
                  awaiting_symbol <= 1'b0;
                  root_valid      <= 1'b0;
                  walk_null       <= 1'b1;
                  phase           <= (tbl_hdr != '0) ? PH_TREE : PH_DATA;
                end
              end
            end
            PH_TREE: begin
              tree_bytes_left <= tree_bytes_left - FW'(1);
              if (tree_bytes_left == FW'(1)) begin
                walk_null <= 1'b1;
                phase     <= PH_DATA;
              end
              state <= S_TB;
            end
            PH_DATA: begin
              bit_idx <= 3'd7;
              state   <= S_BIT;
            end
            default: begin
            end
          endcase
        end
        S_TB: begin
          state <= S_FIN;
          if (!(root_valid && stack_count == '0)) begin
            if (awaiting_symbol) begin
              awaiting_symbol <= 1'b0;
              mk_sym          <= cur_byte;
              mk_internal     <= 1'b0;
              state           <= S_MK;
            end else if (cur_byte == LEAF_MARK) begin
              awaiting_symbol <= 1'b1;
            end else begin
              mk_sym      <= '0;
              mk_internal <= 1'b1;
              state       <= S_MK;
            end
          end
        end
        S_MK: begin
          state <= S_FIN;
          if (build_cursor < NW'(TREE_BYTES)) begin
            new_node     <= build_cursor;
            build_cursor <= build_cursor + NW'(1);
            if (!root_valid) begin
              root_valid <= 1'b1;
              state      <= mk_internal ? S_PUSH1 : S_FIN;
            end else if (stack_count != '0) begin
              stack_count <= stack_count - SW'(1);
              state       <= S_LINK;
            end else begin
              state <= mk_internal ? S_PUSH1 : S_FIN;
            end
          end
        end
        S_LINK: begin
          state <= mk_internal ? S_PUSH1 : S_FIN;
        end
        S_PUSH1: begin
          if (stack_count < SW'(TREE_BYTES + 1)) begin
            stack_count <= stack_count + SW'(1);
          end
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (stack_count < SW'(TREE_BYTES + 1)) begin
            stack_count <= stack_count + SW'(1);
          end
          state <= S_FIN;
        end
        S_BIT: begin
          if (symbols_left == '0) begin
            state <= S_FIN;
          end else if (walk_null && root_valid) begin
            state <= S_ROOT;
          end else if (walk_null || child != NODE_NULL) begin
            if (walk_null) begin
              state <= (bit_idx == 3'd0) ? S_FIN : S_BIT;
              bit_idx <= bit_idx - 3'd1;
            end else begin
              state <= S_CHK;
            end
          end else begin
            walk_null <= 1'b1;
            state     <= (bit_idx == 3'd0) ? S_FIN : S_BIT;
            bit_idx   <= bit_idx - 3'd1;
          end
        end
        S_ROOT: begin
          cur_kid0  <= nd_rd_kid0;
          cur_kid1  <= nd_rd_kid1;
          walk_null <= 1'b0;
          state     <= S_BIT;
        end
        S_CHK: begin
          if (child_leaf) begin
            symbols_left <= symbols_left - FW'(1);
            new_sym      <= nd_rd_sym;
            new_done     <= (symbols_left == FW'(1));
            walk_null    <= 1'b1;
            state        <= S_EMIT;
          end else begin
            cur_kid0 <= nd_rd_kid0;
            cur_kid1 <= nd_rd_kid1;
            state    <= (bit_idx == 3'd0) ? S_FIN : S_BIT;
            bit_idx  <= bit_idx - 3'd1;
          end
        end
        S_EMIT: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              out_valid <= 1'b1;
              symbol    <= hold_sym;
              status    <= hold_status;
              all_done  <= hold_done;
              run_last  <= 1'b0;
            end
            hold_valid  <= 1'b1;
            hold_sym    <= new_sym;
            hold_status <= STATUS_SYMBOL;
            hold_done   <= new_done;
            state       <= (bit_idx == 3'd0) ? S_FIN : S_BIT;
            bit_idx     <= bit_idx - 3'd1;
          end
        end
        S_FIN: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              out_valid  <= 1'b1;
              symbol     <= hold_sym;
              status     <= hold_status;
              all_done   <= hold_done;
              run_last   <= 1'b1;
              hold_valid <= 1'b0;
            end
            if (end_flag) begin
              phase           <= PH_HEADER;
              header_count    <= '0;
              tree_bytes_left <= '0;
              symbols_left    <= '0;
              stack_count     <= '0;
              build_cursor    <= '0;
              awaiting_symbol <= 1'b0;
              root_valid      <= 1'b0;
              walk_null       <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/hcd_node_store.sv =====
// Node table of the decoder: symbol, left child and right child per node.
// One read port with registered data, per-field write enables; uses hcd_pkg.
module hcd_node_store
  import hcd_pkg::*;
#(
  parameter int TREE_BYTES = TREE_BYTES_DEF,
  parameter int NAW = $clog2(TREE_BYTES),
  parameter int NW  = $clog2(TREE_BYTES + 1)
) (
  input  logic           clk,
  input  node_we_t       we,
  input  logic [NAW-1:0] wr_addr,
  input  logic [7:0]     wr_sym,
  input  logic [NW-1:0]  wr_kid0,
  input  logic [NW-1:0]  wr_kid1,
  input  logic [NAW-1:0] rd_addr,
  output logic [7:0]     rd_sym,
  output logic [NW-1:0]  rd_kid0,
  output logic [NW-1:0]  rd_kid1
);

  logic [7:0]    sym_mem  [TREE_BYTES];
  logic [NW-1:0] kid0_mem [TREE_BYTES];
  logic [NW-1:0] kid1_mem [TREE_BYTES];

  always_ff @(posedge clk) begin
    if (we.sym) begin
      sym_mem[wr_addr] <= wr_sym;
    end
    if (we.kid0) begin
      kid0_mem[wr_addr] <= wr_kid0;
    end
    if (we.kid1) begin
      kid1_mem[wr_addr] <= wr_kid1;
    end
    rd_sym  <= sym_mem[rd_addr];
    rd_kid0 <= kid0_mem[rd_addr];
    rd_kid1 <= kid1_mem[rd_addr];
  end

endmodule

// ===== rtl/core/hcd_slot_stack.sv =====
// Pending-slot stack of the tree builder: parent node and side per entry.
// One write and one registered read per cycle; uses hcd_pkg.
module hcd_slot_stack
  import hcd_pkg::*;
#(
  parameter int TREE_BYTES = TREE_BYTES_DEF,
  parameter int SAW = $clog2(TREE_BYTES + 1),
  parameter int NW  = $clog2(TREE_BYTES + 1)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [SAW-1:0] wr_addr,
  input  logic [NW-1:0]  wr_node,
  input  logic           wr_side,
  input  logic [SAW-1:0] rd_addr,
  output logic [NW-1:0]  rd_node,
  output logic           rd_side
);

  logic [NW:0] mem [TREE_BYTES + 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_side, wr_node};
    end
    {rd_side, rd_node} <= mem[rd_addr];
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for huffman_container_decoder_unit.
// Drives byte-wide containers, predicts decoded symbols, checks each result transaction.
// Depends on hcd_pkg and the RTL of the decoder.
module testbench;
  import hcd_pkg::*;

  localparam int TB   = TREE_BYTES_DEF;
  localparam int SFB  = SIZE_FIELD_BYTES_DEF;
  localparam logic [10:0] NUL = 11'(TB);

  typedef enum int {PH_HDR, PH_TREE, PH_DATA, PH_DRAIN} phase_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       status;
    logic       run_last;
    logic       all_done;
  } result_t;

  class decode_scoreboard;
    phase_t      ph;
    int          hdr_cnt;
    logic [63:0] tree_left, syms_left;
    logic [7:0]  nsym[TB];
    logic [10:0] nkid[TB][2];
    logic [10:0] stk_node[TB+1];
    logic        stk_side[TB+1];
    int          stk_cnt, cursor;
    bit          want_sym, root_ok;
    logic [10:0] walk;
    result_t     pending[$];
    int          errors;

    function void restart();
      ph = PH_HDR; hdr_cnt = 0; tree_left = 0; syms_left = 0;
      stk_cnt = 0; cursor = 0; want_sym = 0; root_ok = 0; walk = NUL;
    endfunction

    function logic [10:0] add_node(logic [7:0] s);
      logic [10:0] n;
      if (cursor >= TB) return NUL;
      n = 11'(cursor);
      cursor++;
      nsym[n] = s; nkid[n][0] = NUL; nkid[n][1] = NUL;
      if (!root_ok) root_ok = 1;
      else if (stk_cnt > 0) begin
        stk_cnt--;
        nkid[stk_node[stk_cnt] % TB][stk_side[stk_cnt]] = n;
      end
      return n;
    endfunction

    function void push(logic [10:0] p, bit sd);
      if (stk_cnt < TB + 1) begin
        stk_node[stk_cnt] = p; stk_side[stk_cnt] = sd; stk_cnt++;
      end
    endfunction

    function void tree_in(logic [7:0] b);
      logic [10:0] n;
      if (root_ok && stk_cnt == 0) return;
      if (want_sym) begin
        want_sym = 0; void'(add_node(b));
      end else if (b == LEAF_MARK) begin
        want_sym = 1;
      end else begin
        n = add_node(8'd0);
        if (n != NUL) begin
          push(n, 1); push(n, 0);
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      result_t r[$];
      result_t t;
      bit d;
      case (ph)
        PH_HDR: begin
          if (hdr_cnt < SFB) tree_left |= 64'(b) << (8 * hdr_cnt);
          else syms_left |= 64'(b) << (8 * ((hdr_cnt - SFB) & 7));
          hdr_cnt++;
          if (hdr_cnt >= 2 * SFB) begin
            hdr_cnt = 0;
            if (tree_left > TB) begin
              t = '{8'd0, STATUS_OVERSIZE, 1'b0, 1'b0};
              r = {r, t};
              ph = PH_DRAIN;
            end else begin
              stk_cnt = 0; cursor = 0; want_sym = 0; root_ok = 0; walk = NUL;
              ph = (tree_left != 0) ? PH_TREE : PH_DATA;
            end
          end
        end
        PH_TREE: begin
          tree_in(b);
          tree_left--;
          if (tree_left == 0) begin
            walk = NUL; ph = PH_DATA;
          end
        end
        PH_DATA: begin
          for (int i = 7; i >= 0; i--) begin
            if (syms_left == 0) break;
            d = b[i];
            if (walk == NUL) begin
              if (!root_ok) continue;
              walk = 0;
            end
            walk = nkid[walk % TB][d];
            if (walk != NUL && nkid[walk][0] == NUL && nkid[walk][1] == NUL) begin
              syms_left--;
              t = '{nsym[walk], STATUS_SYMBOL, 1'b0, syms_left == 0};
              r = {r, t};
              walk = NUL;
            end
          end
          if (syms_left == 0) ph = PH_DRAIN;
        end
        default: ;
      endcase
      if (r.size() > 0) r[r.size()-1].run_last = 1;
      foreach (r[i]) pending = {pending, r[i]};
      if (last) restart();
    endfunction

    function void check(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result symbol=%0d status=%0b", got.symbol, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.symbol !== e.symbol) begin
        $error("symbol exp %0d got %0d", e.symbol, got.symbol); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0b got %0b", e.status, got.status); errors++;
      end
      if (got.run_last !== e.run_last) begin
        $error("run_last exp %0b got %0b", e.run_last, got.run_last); errors++;
      end
      if (got.all_done !== e.all_done) begin
        $error("all_done exp %0b got %0b", e.all_done, got.all_done); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, stream_end, out_valid, out_stall;
  logic [7:0] in_byte, symbol;
  logic status, run_last, all_done;
  int src_idle, sink_idle;

  decode_scoreboard sb;
  logic [7:0] cbytes[$];

  huffman_container_decoder_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .stream_end(stream_end), .out_valid(out_valid),
    .out_stall(out_stall), .symbol(symbol), .status(status),
    .run_last(run_last), .all_done(all_done)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check('{symbol, status, run_last, all_done});
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < sink_idle);
  end

  task automatic send(logic [7:0] b, logic last);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 0;
      in_byte <= 8'($urandom);
      stream_end <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1; in_byte <= b; stream_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic send_stream();
    foreach (cbytes[i]) send(cbytes[i], i == cbytes.size() - 1);
    cbytes.delete();
    in_valid <= 0;
    in_byte <= 8'($urandom);
    stream_end <= 1'($urandom);
    @(posedge clk);
  endtask

  task automatic add_header(logic [63:0] tl, logic [63:0] cnt);
    for (int i = 0; i < SFB; i++) cbytes = {cbytes, tl[8*i +: 8]};
    for (int i = 0; i < SFB; i++) cbytes = {cbytes, cnt[8*i +: 8]};
  endtask

  // random preorder tree with nleaf leaves (one leaf for nleaf below 2)
  task automatic add_tree(int nleaf, inout logic [7:0] t[$]);
    if (nleaf <= 1) begin
      t = {t, LEAF_MARK}; t = {t, 8'($urandom)};
    end else begin
      int l;
      l = $urandom_range(nleaf - 1, 1);
      t = {t, 8'($urandom_range(255, 2)) & 8'hFE | 8'h2};
      add_tree(l, t);
      add_tree(nleaf - l, t);
    end
  endtask

  task automatic container(int nleaf, int nsym, int ndata, bit trunc, bit extra);
    logic [7:0] t[$];
    int len;
    add_tree(nleaf, t);
    if (trunc && t.size() > 1) t = t[0:$urandom_range(t.size()-2)];
    len = t.size();
    if (extra) begin
      repeat ($urandom_range(3, 1)) t = {t, 8'($urandom)};
      len = t.size();
    end
    add_header(64'(len), 64'(nsym));
    foreach (t[i]) cbytes = {cbytes, t[i]};
    repeat (ndata) cbytes = {cbytes, 8'($urandom)};
    send_stream();
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk); n++;
    end
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int ph;
    sb = new();
    sb.errors = 0;
    sb.restart();
    rst = 1; in_valid = 0; in_byte = 0; stream_end = 0; out_stall = 0;
    src_idle = 0; sink_idle = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // oversized tree, extremes of header bytes
    add_header(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    cbytes = {cbytes, 8'hFF}; cbytes = {cbytes, 8'h00};
    send_stream();
    add_header(64'(TB + 1), 64'd3);
    send_stream();
    // empty tree, single leaf, truncated, surplus, zero count, early end
    add_header(64'd0, 64'd5); cbytes = {cbytes, 8'hA5}; send_stream();
    add_header(64'd2, 64'd5); cbytes = {cbytes, LEAF_MARK}; cbytes = {cbytes, 8'h42};
    cbytes = {cbytes, 8'h0F}; send_stream();
    container(4, 0, 2, 0, 0);
    container(3, 20, 4, 1, 0);
    container(5, 6, 6, 0, 1);
    add_header(64'd3, 64'd2); cbytes = {cbytes, 8'h00}; cbytes = {cbytes, LEAF_MARK};
    send_stream();
    add_header(64'd9, 64'd1); cbytes = {cbytes, 8'h00}; send_stream();
    drain();
    for (ph = 0; ph < 4; ph++) begin
      src_idle  = (ph == 1 || ph == 3) ? (ph == 3 ? 7 : 81) : 0;
      sink_idle = (ph == 2 || ph == 3) ? (ph == 3 ? 7 : 81) : 0;
      for (int k = 0; k < 2; k++) begin
        int r;
        r = $urandom_range(99);
        if (r < 80) container($urandom_range(8, 2), $urandom_range(16, 1),
                              $urandom_range(10, 2), 0, r < 10);
        else if (r < 88) container($urandom_range(6, 1), $urandom_range(9, 1),
                                   $urandom_range(5, 1), 1, 0);
        else if (r < 94) begin
          add_header(64'(TB + $urandom_range(50)), 64'($urandom));
          cbytes = {cbytes, 8'($urandom)}; send_stream();
        end else begin
          repeat ($urandom_range(20, 1)) cbytes = {cbytes, 8'($urandom)};
          send_stream();
        end
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/hcd_pkg.sv
rtl/core/hcd_node_store.sv
rtl/core/hcd_slot_stack.sv
rtl/core/huffman_container_decoder_unit.sv
tb/testbench.sv
